// ===== hdl/dbnc_pkg.sv =====
package dbnc_pkg;

   localparam int DEFAULT_NUM_CHANNELS = 3;
   localparam int PINNED_CHANNELS      = 3;
   localparam int QUEUE_DEPTH          = 2;

   localparam int LEVELS_W   = 16;
   localparam int TIME_W     = 32;
   localparam int DEBOUNCE_W = 16;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] REG_LOCKOUT_MS = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ENABLED    = 1'd1;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

   localparam logic [1:0] WF_OFF      = 2'd0;
   localparam logic [1:0] WF_SINE     = 2'd1;
   localparam logic [1:0] WF_SQUARE   = 2'd2;
   localparam logic [1:0] WF_TRIANGLE = 2'd3;

   localparam logic [1:0] OCT_ZERO = 2'd0;
   localparam logic [1:0] OCT_UP   = 2'd1;
   localparam logic [1:0] OCT_DOWN = 2'd3;

   localparam logic KIND_WAVEFORM = 1'b0;
   localparam logic KIND_OCTAVE   = 1'b1;

   typedef struct packed {
      logic [3:0] a;
      logic [3:0] b;
      logic [3:0] c;
      logic [3:0] up;
      logic [3:0] down;
   } pin_set_type;

   localparam pin_set_type PIN_MAP [PINNED_CHANNELS] = '{
      '{a: 4'd6, b: 4'd5,  c: 4'd14, up: 4'd7,  down: 4'd15},
      '{a: 4'd4, b: 4'd11, c: 4'd3,  up: 4'd12, down: 4'd13},
      '{a: 4'd1, b: 4'd9,  c: 4'd0,  up: 4'd10, down: 4'd2}
   };

   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [1:0] value;
   } event_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hdl/dbnc_front.sv =====
module dbnc_front
   import dbnc_pkg::*;
#(
   parameter int ACTIVE = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [LEVELS_W-1:0]   switch_levels,
   input  logic [TIME_W-1:0]     now_ms,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  queue_status_type      queue_status,
   output logic                  push,
   output event_type [ACTIVE-1:0] bundle
);

   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic                  enabled_ff;
   logic [1:0]            held_wf_ff  [ACTIVE];
   logic [1:0]            held_oct_ff [ACTIVE];
   logic [TIME_W-1:0]     last_time_ff [ACTIVE];
   logic                  accept;
   logic                  update;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign update    = accept && enabled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         enabled_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_LOCKOUT_MS: debounce_ff <= csr_wdata;
            REG_ENABLED:    enabled_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   for (genvar c = 0; c < ACTIVE; c++) begin : g_chan
      logic [1:0]        wf;
      logic [1:0]        oct;
      logic              up_on;
      logic              down_on;
      logic [TIME_W-1:0] elapsed;
      logic              open;
      logic              wf_chg;
      logic              oct_chg;

      always_comb begin
         if (!switch_levels[PIN_MAP[c].a]) begin
            wf = WF_SINE;
         end else if (!switch_levels[PIN_MAP[c].b]) begin
            wf = WF_SQUARE;
         end else if (!switch_levels[PIN_MAP[c].c]) begin
            wf = WF_TRIANGLE;
         end else begin
            wf = WF_OFF;
         end
         up_on   = !switch_levels[PIN_MAP[c].up];
         down_on = !switch_levels[PIN_MAP[c].down];
         if (up_on && !down_on) begin
            oct = OCT_UP;
         end else if (down_on && !up_on) begin
            oct = OCT_DOWN;
         end else begin
            oct = OCT_ZERO;
         end
         elapsed = now_ms - last_time_ff[c];
         open    = elapsed > {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ff};
         wf_chg  = open && (wf != held_wf_ff[c]);
         oct_chg = open && !wf_chg && (oct != held_oct_ff[c]);
         bundle[c].valid = wf_chg || oct_chg;
         bundle[c].kind  = wf_chg ? KIND_WAVEFORM : KIND_OCTAVE;
         bundle[c].value = wf_chg ? wf : oct;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            held_wf_ff[c]   <= WF_OFF;
            held_oct_ff[c]  <= OCT_ZERO;
            last_time_ff[c] <= '0;
         end else if (update) begin
            if (wf_chg) begin
               held_wf_ff[c] <= wf;
            end
            if (oct_chg) begin
               held_oct_ff[c] <= oct;
            end
            if (wf_chg || oct_chg) begin
               last_time_ff[c] <= now_ms;
            end
         end
      end
   end

   always_comb begin
      push = 1'b0;
      for (int i = 0; i < ACTIVE; i++) begin
         push = push | bundle[i].valid;
      end
      push = push && update;
   end

endmodule

// ===== hdl/dbnc_queue.sv =====
module dbnc_queue
   import dbnc_pkg::*;
#(
   parameter int WIDTH = 12,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/dbnc_back.sv =====
module dbnc_back
   import dbnc_pkg::*;
#(
   parameter int ACTIVE = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  event_type [ACTIVE-1:0] head,
   input  queue_status_type       queue_status,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tlast
);

   logic [ACTIVE-1:0] done_ff;
   logic [ACTIVE-1:0] done_in;
   logic [ACTIVE-1:0] pending;
   logic [ACTIVE-1:0] sel;
   logic [1:0]        osc_index;
   logic              kind;
   logic [1:0]        value;
   logic              beat;

   always_comb begin
      for (int i = 0; i < ACTIVE; i++) begin
         pending[i] = head[i].valid && !done_ff[i];
      end
      sel       = pending & (~pending + 1'b1);
      osc_index = 2'd0;
      kind      = 1'b0;
      value     = 2'd0;
      for (int i = 0; i < ACTIVE; i++) begin
         if (sel[i]) begin
            osc_index = 2'(i);
            kind      = head[i].kind;
            value     = head[i].value;
         end
      end
   end

   assign rsp_tvalid = !queue_status.empty;
   assign rsp_tlast  = (pending & ~sel) == '0;
   assign rsp_tdata  = {1'b0,
                        (kind == KIND_OCTAVE)   ? value : OCT_ZERO,
                        (kind == KIND_WAVEFORM) ? value : WF_OFF,
                        kind,
                        osc_index};
   assign beat       = rsp_tvalid && rsp_tready;
   assign pop        = beat && rsp_tlast;

   always_comb begin
      done_in = done_ff;
      if (pop) begin
         done_in = '0;
      end else if (beat) begin
         done_in = done_ff | sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
      end else begin
         done_ff <= done_in;
      end
   end

endmodule

// ===== hdl/three_channel_switch_debouncer.sv =====
// Channel   Direction  Payload
// req_      in         tdata: switch_levels[15:0], now_ms[47:16]
// rsp_      out        tdata: osc_index, change_kind, waveform, octave; tlast
// csr_      in         write enable, index 0 lockout time in ms, index 1 enabled
//
// One snapshot is taken per cycle while the two-entry event queue has room.
// Each snapshot that changes something gives one to three beats on rsp_, one
// per cycle while rsp_tready is high, from the queue head; the back end sets rate.
// Synchronous reset clears held state and queue and restores register defaults.
// A stall on rsp_ fills the queue and then holds req_tready low.
module three_channel_switch_debouncer
   import dbnc_pkg::*;
#(
   parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: switch_levels (16), now_ms (32).
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: osc_index (2), change_kind (1), waveform (2), octave (2), pad.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ACTIVE = (NUM_CHANNELS < PINNED_CHANNELS) ? NUM_CHANNELS : PINNED_CHANNELS;
   localparam int BUNDLE_W = ACTIVE * $bits(event_type);

   queue_status_type       queue_status;
   logic                   push;
   logic                   pop;
   event_type [ACTIVE-1:0] push_bundle;
   event_type [ACTIVE-1:0] head_bundle;

   dbnc_front #(.ACTIVE(ACTIVE)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .switch_levels (req_tdata[LEVELS_W-1:0]),
      .now_ms        (req_tdata[LEVELS_W+TIME_W-1:LEVELS_W]),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .queue_status  (queue_status),
      .push          (push),
      .bundle        (push_bundle)
   );

   dbnc_queue #(.WIDTH(BUNDLE_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_bundle),
      .pop       (pop),
      .head_data (head_bundle),
      .status    (queue_status)
   );

   dbnc_back #(.ACTIVE(ACTIVE)) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head_bundle),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// ===== hdl/dbnc_checker.sv =====
module dbnc_checker
   import dbnc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Result beat changed while stalled.");

   a_rsp_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3 && rsp_tdata[6:5] != 2'b10 && !rsp_tdata[7])
      else $error("Result beat carries an impossible code.");

   a_unused_field: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2] ? rsp_tdata[4:3] == WF_OFF : rsp_tdata[6:5] == OCT_ZERO))
      else $error("Field without meaning is not zero.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result beat offered straight after reset.");

endmodule

bind three_channel_switch_debouncer dbnc_checker u_dbnc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== test/switch_event_checker.sv =====
`timescale 1ns / 1ps

// Watches the three ports of the debouncer. It predicts the events that each
// accepted snapshot should raise and compares every rsp_ beat with the oldest
// event still waiting.
module switch_event_checker
   import dbnc_pkg::*;
#(
   parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct packed {
      logic [1:0] osc_index;
      logic       change_kind;
      logic [1:0] waveform;
      logic [1:0] octave;
      logic       last;
   } switch_event_type;

   switch_event_type      expected_events [$];
   logic [DEBOUNCE_W-1:0] lockout_ms;
   logic                  enabled;
   logic [1:0]            held_waveform [PINNED_CHANNELS];
   logic [1:0]            held_octave   [PINNED_CHANNELS];
   logic [TIME_W-1:0]     changed_at    [PINNED_CHANNELS];

   function automatic pin_set_type pins_of(input int ch);
      case (ch)
         0: pins_of = {4'd6, 4'd5, 4'd14, 4'd7, 4'd15};
         1: pins_of = {4'd4, 4'd11, 4'd3, 4'd12, 4'd13};
         default: pins_of = {4'd1, 4'd9, 4'd0, 4'd10, 4'd2};
      endcase
   endfunction

   function automatic logic pressed(input logic [LEVELS_W-1:0] levels, input logic [3:0] pin);
      return levels[pin] == 1'b0;
   endfunction

   function automatic logic [1:0] selected_waveform(input logic [LEVELS_W-1:0] levels,
                                                    input pin_set_type p);
      if (pressed(levels, p.a)) return WF_SINE;
      if (pressed(levels, p.b)) return WF_SQUARE;
      if (pressed(levels, p.c)) return WF_TRIANGLE;
      return WF_OFF;
   endfunction

   function automatic logic [1:0] octave_shift(input logic [LEVELS_W-1:0] levels,
                                               input pin_set_type p);
      if (pressed(levels, p.up) && !pressed(levels, p.down)) return OCT_UP;
      if (pressed(levels, p.down) && !pressed(levels, p.up)) return OCT_DOWN;
      return OCT_ZERO;
   endfunction

   // A waveform change that is taken restarts the lockout, so an octave change
   // on the same channel in the same snapshot is held back.
   task automatic predict_switch_events(input logic [LEVELS_W-1:0] levels,
                                        input logic [TIME_W-1:0] now);
      switch_event_type  found [2*PINNED_CHANNELS];
      switch_event_type  one;
      pin_set_type       p;
      logic [1:0]        wave;
      logic [1:0]        shift;
      logic [TIME_W-1:0] elapsed;
      int                count;
      int                ch;
      int                i;
      count = 0;
      if (!enabled) return;
      for (ch = 0; ch < NUM_CHANNELS && ch < PINNED_CHANNELS; ch++) begin
         p = pins_of(ch);
         wave = selected_waveform(levels, p);
         shift = octave_shift(levels, p);
         elapsed = now - changed_at[ch];
         if (wave != held_waveform[ch] && elapsed > TIME_W'(lockout_ms)) begin
            held_waveform[ch] = wave;
            changed_at[ch] = now;
            found[count] = {2'(ch), KIND_WAVEFORM, wave, OCT_ZERO, 1'b0};
            count++;
         end
         elapsed = now - changed_at[ch];
         if (shift != held_octave[ch] && elapsed > TIME_W'(lockout_ms)) begin
            held_octave[ch] = shift;
            changed_at[ch] = now;
            found[count] = {2'(ch), KIND_OCTAVE, WF_OFF, shift, 1'b0};
            count++;
         end
      end
      for (i = 0; i < count; i++) begin
         one = found[i];
         one.last = (i == count - 1);
         expected_events.push_back(one);
      end
   endtask

   task automatic compare_field(input string name, input logic [1:0] want,
                                input logic [1:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   task automatic check_beat();
      switch_event_type want;
      if (expected_events.size() == 0) begin
         mismatches++;
         $error("rsp beat with no event expected: tdata 0x%02h, tlast %b",
                rsp_tdata, rsp_tlast);
         return;
      end
      want = expected_events.pop_front();
      compare_field("osc_index", want.osc_index, rsp_tdata[1:0]);
      compare_field("change_kind", 2'(want.change_kind), 2'(rsp_tdata[2]));
      compare_field("waveform", want.waveform, rsp_tdata[4:3]);
      compare_field("octave", want.octave, rsp_tdata[6:5]);
      compare_field("last", 2'(want.last), 2'(rsp_tlast));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lockout_ms = DEBOUNCE_RESET;
         enabled = 1'b0;
         foreach (held_waveform[i]) begin
            held_waveform[i] = WF_OFF;
            held_octave[i] = OCT_ZERO;
            changed_at[i] = '0;
         end
         expected_events.delete();
         mismatches = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_beat();
         if (req_tvalid && req_tready)
            predict_switch_events(req_tdata[LEVELS_W-1:0], req_tdata[LEVELS_W +: TIME_W]);
         if (csr_we) begin
            case (csr_addr)
               REG_LOCKOUT_MS: lockout_ms = csr_wdata[DEBOUNCE_W-1:0];
               REG_ENABLED: enabled = csr_wdata[0];
               default: ;
            endcase
         end
      end
      outstanding <= expected_events.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import dbnc_pkg::*;

   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_BEATS   = 78;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // Fields from bit 0: switch_levels (16), now_ms (32).
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // Fields from bit 0: osc_index (2), change_kind (1), waveform (2), octave (2), pad.
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   int                    mismatches;
   int                    outstanding;

   int                    tx_idle_pct = 10;
   int                    rx_idle_pct = 51;
   int                    holds_asked = 0;
   int                    holds_done  = 0;
   int                    hold_left   = 0;
   int                    quiet_cycles = 0;
   logic [DEBOUNCE_W-1:0] lockout = DEBOUNCE_RESET;
   logic [TIME_W-1:0]     now_ms = '0;
   logic [1:0]            aim_waveform [PINNED_CHANNELS];
   logic [1:0]            aim_octave   [PINNED_CHANNELS];

   always #10 clock = ~clock;

   three_channel_switch_debouncer uut (.*);

   switch_event_checker event_check (.*);

   // A requested hold-off keeps rsp_tready low long enough for the event queue
   // to fill and for req_tready to fall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holds_done < holds_asked) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic pin_set_type pins_of(input int ch);
      case (ch)
         0: pins_of = {4'd6, 4'd5, 4'd14, 4'd7, 4'd15};
         1: pins_of = {4'd4, 4'd11, 4'd3, 4'd12, 4'd13};
         default: pins_of = {4'd1, 4'd9, 4'd0, 4'd10, 4'd2};
      endcase
   endfunction

   // Pins that the aimed positions leave free, and pin 8, take random levels.
   function automatic logic [LEVELS_W-1:0] compose_levels();
      logic [LEVELS_W-1:0] levels;
      pin_set_type         p;
      levels = LEVELS_W'($urandom);
      for (int ch = 0; ch < PINNED_CHANNELS; ch++) begin
         p = pins_of(ch);
         case (aim_waveform[ch])
            WF_SINE: levels[p.a] = 1'b0;
            WF_SQUARE: begin
               levels[p.a] = 1'b1;
               levels[p.b] = 1'b0;
            end
            WF_TRIANGLE: begin
               levels[p.a] = 1'b1;
               levels[p.b] = 1'b1;
               levels[p.c] = 1'b0;
            end
            default: begin
               levels[p.a] = 1'b1;
               levels[p.b] = 1'b1;
               levels[p.c] = 1'b1;
            end
         endcase
         case (aim_octave[ch])
            OCT_UP: begin
               levels[p.up] = 1'b0;
               levels[p.down] = 1'b1;
            end
            OCT_DOWN: begin
               levels[p.up] = 1'b1;
               levels[p.down] = 1'b0;
            end
            default: levels[p.down] = levels[p.up];
         endcase
      end
      return levels;
   endfunction

   task automatic aim(input int ch, input logic [1:0] wave, input logic [1:0] shift);
      aim_waveform[ch] = wave;
      aim_octave[ch] = shift;
   endtask

   task automatic pick_aims();
      for (int ch = 0; ch < PINNED_CHANNELS; ch++) begin
         if ($urandom_range(99) < 35) aim_waveform[ch] = 2'($urandom_range(3));
         if ($urandom_range(99) < 25) begin
            case ($urandom_range(2))
               0: aim_octave[ch] = OCT_ZERO;
               1: aim_octave[ch] = OCT_UP;
               default: aim_octave[ch] = OCT_DOWN;
            endcase
         end
      end
   endtask

   // Half the steps clear the lockout; the rest land inside it, on its edge, or
   // jump anywhere, including backwards and across the wrap.
   task automatic advance_clock();
      case ($urandom_range(9))
         0, 1, 2, 3: now_ms = now_ms + lockout + 1 + $urandom_range(40);
         4, 5: now_ms = now_ms + $urandom_range(lockout);
         6: now_ms = now_ms + lockout;
         7: now_ms = now_ms + lockout + 1;
         8: now_ms = now_ms + 1;
         default: now_ms = $urandom;
      endcase
   endtask

   task automatic send_snapshot(input logic [LEVELS_W-1:0] levels,
                                input logic [TIME_W-1:0] stamp);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {stamp, levels};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic shoot(input logic [LEVELS_W-1:0] levels, input logic [TIME_W-1:0] stamp);
      now_ms = stamp;
      send_snapshot(levels, stamp);
   endtask

   // A snapshot that raises nothing may still be in flight once the queue of
   // expected events is empty, hence the extra cycles.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int phase;
      int beat;
      for (int ch = 0; ch < PINNED_CHANNELS; ch++) aim(ch, WF_SINE, OCT_UP);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The block comes out of reset disabled and must stay silent.
      shoot(compose_levels(), 32'd1000);
      shoot(16'h0000, 32'd2000);
      shoot(16'hFFFF, 32'hFFFF_FFFF);
      settle();
      write_reg(REG_ENABLED, 16'd1);

      shoot(16'h0000, 32'd51);
      shoot(16'hFFFF, 32'd52);
      shoot(16'hFFFF, 32'd101);
      shoot(16'hFFFF, 32'd102);
      for (int ch = 0; ch < PINNED_CHANNELS; ch++) aim(ch, WF_OFF, OCT_UP);
      shoot(compose_levels(), 32'd200);
      aim(0, WF_SQUARE, OCT_DOWN);
      aim(1, WF_TRIANGLE, OCT_UP);
      aim(2, WF_OFF, OCT_DOWN);
      shoot(compose_levels(), 32'd300);
      shoot(compose_levels(), 32'd351);
      for (int ch = 0; ch < PINNED_CHANNELS; ch++) aim(ch, WF_TRIANGLE, OCT_ZERO);
      shoot(compose_levels(), 32'hFFFF_FFF0);
      for (int ch = 0; ch < PINNED_CHANNELS; ch++) aim(ch, WF_SINE, OCT_ZERO);
      shoot(compose_levels(), 32'h0000_0010);
      shoot(compose_levels(), 32'h0000_0023);
      shoot(compose_levels(), 32'h0000_0056);
      for (int ch = 0; ch < PINNED_CHANNELS; ch++) aim(ch, WF_SQUARE, OCT_DOWN);
      shoot(compose_levels(), 32'h0000_0030);
      shoot(16'h0000, 32'hFFFF_FFFF);
      settle();

      for (phase = 0; phase < 6; phase++) begin
         tx_idle_pct = (phase < 2) ? 10 : (phase < 4) ? 51 : 0;
         rx_idle_pct = (phase < 2) ? 51 : (phase < 4) ? 10 : 0;
         case (phase)
            0: lockout = '0;
            1: lockout = '1;
            2: lockout = DEBOUNCE_RESET;
            4: lockout = 16'd1;
            default: lockout = DEBOUNCE_W'($urandom_range(1000, 2));
         endcase
         if (phase == 3) begin
            write_reg(REG_ENABLED, 16'd0);
            for (beat = 0; beat < 20; beat++) begin
               advance_clock();
               send_snapshot(LEVELS_W'($urandom), now_ms);
            end
            settle();
            write_reg(REG_ENABLED, 16'd1);
         end
         write_reg(REG_LOCKOUT_MS, lockout);
         for (beat = 0; beat < PHASE_BEATS; beat++) begin
            if (beat == PHASE_BEATS / 2) settle();
            if (beat == 10 && (phase == 1 || phase == 4)) holds_asked++;
            advance_clock();
            if ($urandom_range(99) < 85) begin
               pick_aims();
               send_snapshot(compose_levels(), now_ms);
            end else begin
               send_snapshot(LEVELS_W'($urandom), now_ms);
            end
         end
         settle();
      end

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
